@@ hw/rtl/tlba_pkg.sv @@
// Shared constants, codes and control structs for the two-level bitmap allocator.
// No dependencies; every other file of the block imports this package.
package tlba_pkg;

  // Default geometry of the region.
  localparam int CHUNKS_PER_BRANCH_DEF = 32;
  localparam int BRANCHES_DEF          = 16;
  localparam int BRANCHES_PER_BANK_DEF = 4;
  localparam int BANKS_DEF             = 4;
  localparam int SPACE_BITS_DEF        = 3;
  localparam int BYTE_BITS_DEF         = 14;

  // Fixed field widths of the request and response words.
  localparam int OP_W   = 2;
  localparam int BANK_W = 2;
  localparam int ADDR_W = 26;
  // Width of a bank's bump pointer, in spaces.
  localparam int NEXT_W = 13;

  // Command codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // zero one counter entry of the clearing pass
    logic lookup;  // request accepted: search bitmaps, read counters
    logic update;  // write back counters, bitmaps and bank state
  } tlba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;      // clearing pass is at its final entry
    logic result_pending;  // the word under work produces a response
    logic out_busy;        // response register still holds an untaken word
  } tlba_status_t;

endpackage

@@ hw/rtl/tlba_if.sv @@
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on tlba_pkg for the payload widths.
interface tlba_req_if import tlba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BANK_W-1:0] bank;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output op, output bank, output free_address, input ready);
  modport sink (input valid, input op, input bank, input free_address, output ready);
endinterface

interface tlba_rsp_if import tlba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              failed;

  modport source (output valid, output address, output failed, input ready);
  modport sink (input valid, input address, input failed, output ready);
endinterface

@@ hw/rtl/tlba_ctrl.sv @@
// Sequencer of the allocator: clearing pass, request accept and write-back.
// Depends on tlba_pkg for the command and status structs.
module tlba_ctrl import tlba_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tlba_status_t status,
  output tlba_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state;
  logic   update_go;

  // Write-back waits only when it has a response to place and the slot is full.
  assign update_go = (state == ST_UPDATE) && !(status.result_pending && status.out_busy);

  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.lookup = in_valid && in_ready;
  assign cmd.update = update_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      in_ready <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_UPDATE;
            in_ready <= 1'b0;
          end
        end
        ST_UPDATE: begin
          if (update_go) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/tlba_datapath.sv @@
// Datapath of the allocator: bitmaps, bank registers, counter memory, response register.
// Depends on tlba_pkg and tlba_rsp_if.
module tlba_datapath import tlba_pkg::*; #(
  parameter int CHUNKS_PER_BRANCH = CHUNKS_PER_BRANCH_DEF,
  parameter int BRANCHES          = BRANCHES_DEF,
  parameter int BRANCHES_PER_BANK = BRANCHES_PER_BANK_DEF,
  parameter int BANKS             = BANKS_DEF,
  parameter int SPACE_BITS        = SPACE_BITS_DEF,
  parameter int BYTE_BITS         = BYTE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tlba_cmd_t         cmd,
  output tlba_status_t      status,
  input  logic [OP_W-1:0]   op,
  input  logic [BANK_W-1:0] bank,
  input  logic [ADDR_W-1:0] free_address,
  tlba_rsp_if.source        rsp
);

  localparam int TOTAL   = BRANCHES * CHUNKS_PER_BRANCH;
  localparam int CHUNK_W = $clog2(TOTAL);
  localparam int BR_W    = $clog2(BRANCHES);
  localparam int CH_W    = $clog2(CHUNKS_PER_BRANCH);
  localparam int U_W     = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int CNT_W   = 2 * SPACE_BITS;
  localparam int GRP_W   = BANKS * BRANCHES_PER_BANK;
  localparam int PAD_W   = (GRP_W > BRANCHES) ? GRP_W : BRANCHES;
  localparam int PADB_W  = (BANKS > (1 << BANK_W)) ? BANKS : (1 << BANK_W);
  localparam int SHIFT   = SPACE_BITS + BYTE_BITS;

  typedef enum logic [2:0] {
    K_FAIL,  // invalid command or no room anywhere
    K_BUMP,  // bank hands out the next space of its current chunk
    K_TAKE,  // bank opens the lowest free chunk of its branches
    K_FREE,  // free of a chunk inside the region
    K_SKIP   // free beyond the region
  } kind_t;

  // Bitmaps and bank state.
  logic [BRANCHES-1:0]          branch_free;
  logic [CHUNKS_PER_BRANCH-1:0] chunk_free [BRANCHES];
  logic [BANKS-1:0]             bank_valid;
  logic [CHUNK_W-1:0]           bank_idx [BANKS];
  logic [NEXT_W-1:0]            bank_next [BANKS];

  // Per-chunk counters: allocation count high, free count low.
  logic [CNT_W-1:0]   counts [TOTAL];
  logic [CNT_W-1:0]   rd_data;
  logic [CHUNK_W-1:0] clr_addr;

  // Word under work, captured at accept.
  kind_t              r_kind;
  logic [U_W-1:0]     r_u;
  logic [CHUNK_W-1:0] r_idx;
  logic [BR_W-1:0]    r_br;
  logic [CH_W-1:0]    r_ch;
  logic [NEXT_W-1:0]  r_next;

  // Lookup results.
  logic [GRP_W-1:0]             grp_bits;
  logic [PAD_W-1:0]             grp_pad;
  logic [BANKS-1:0]             bank_has;
  logic [PADB_W-1:0]            has_pad;
  logic [U_W-1:0]               lk_u;
  logic [BR_W-1:0]              br_new;
  logic [CHUNKS_PER_BRANCH-1:0] row_new;
  logic [CH_W-1:0]              ch_new;
  logic [CHUNK_W-1:0]           idx_new;
  logic [31:0]                  fchunk;
  logic                         f_in_range;
  kind_t                        lk_kind;
  logic [CHUNK_W-1:0]           lk_idx;
  logic [BR_W-1:0]              lk_br;
  logic [CH_W-1:0]              lk_ch;

  // Update results.
  logic [SPACE_BITS-1:0]        acnt;
  logic [SPACE_BITS-1:0]        fcnt;
  logic                         chunk_full;
  logic                         row_empty;
  logic                         chunk_back;
  logic                         wr_en;
  logic [CNT_W-1:0]             wr_data;
  logic                         produce;
  logic [ADDR_W-1:0]            res_addr;
  logic                         res_fail;

  // Branch of a chunk number, by comparing against each branch's first chunk.
  function automatic logic [BR_W-1:0] branch_of(input logic [CHUNK_W-1:0] idx);
    logic [BR_W-1:0] br;
    br = '0;
    for (int k = 1; k < BRANCHES; k++) begin
      if (32'(idx) >= 32'(k * CHUNKS_PER_BRANCH)) br = BR_W'(k);
    end
    return br;
  endfunction

  function automatic logic [ADDR_W-1:0] space_addr(input logic [NEXT_W-1:0] space);
    logic [63:0] wide;
    wide = 64'(space) << BYTE_BITS;
    return wide[ADDR_W-1:0];
  endfunction

  // ---------------------------------------------------------------- lookup
  always_comb begin
    grp_pad  = PAD_W'(branch_free);
    grp_bits = grp_pad[GRP_W-1:0];
    for (int b = 0; b < BANKS; b++) begin
      bank_has[b] = |grp_bits[b*BRANCHES_PER_BANK +: BRANCHES_PER_BANK];
    end
    // A preferred bank beyond BANKS lands on a zero pad bit.
    has_pad = PADB_W'(bank_has);
    if (has_pad[bank]) begin
      lk_u = U_W'(bank);
    end else begin
      lk_u = '0;
      for (int b = 0; b < BANKS; b++) begin
        if (bank_has[b]) lk_u = U_W'(b);
      end
    end

    br_new = '0;
    for (int i = BRANCHES_PER_BANK - 1; i >= 0; i--) begin
      if (grp_bits[32'(lk_u) * BRANCHES_PER_BANK + i]) begin
        br_new = BR_W'(32'(lk_u) * BRANCHES_PER_BANK + i);
      end
    end
    row_new = chunk_free[br_new];
    ch_new  = '0;
    for (int c = CHUNKS_PER_BRANCH - 1; c >= 0; c--) begin
      if (row_new[c]) ch_new = CH_W'(c);
    end
    idx_new = CHUNK_W'(32'(br_new) * CHUNKS_PER_BRANCH + 32'(ch_new));

    fchunk     = 32'(free_address) >> SHIFT;
    f_in_range = fchunk < 32'(TOTAL);

    lk_kind = K_FAIL;
    lk_idx  = '0;
    case (op)
      OP_ALLOC: begin
        if (!(|bank_has)) begin
          lk_kind = K_FAIL;
        end else if (bank_valid[lk_u]) begin
          lk_kind = K_BUMP;
          lk_idx  = bank_idx[lk_u];
        end else begin
          lk_kind = K_TAKE;
          lk_idx  = idx_new;
        end
      end
      OP_FREE: begin
        if (f_in_range) begin
          lk_kind = K_FREE;
          lk_idx  = CHUNK_W'(fchunk);
        end else begin
          lk_kind = K_SKIP;
        end
      end
      default: lk_kind = K_FAIL;
    endcase
    lk_br = branch_of(lk_idx);
    lk_ch = CH_W'(32'(lk_idx) - 32'(lk_br) * CHUNKS_PER_BRANCH);
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      r_kind  <= lk_kind;
      r_u     <= lk_u;
      r_idx   <= lk_idx;
      r_br    <= lk_br;
      r_ch    <= lk_ch;
      r_next  <= bank_next[lk_u];
      rd_data <= counts[lk_idx];
    end
  end

  // ---------------------------------------------------------------- update
  always_comb begin
    acnt       = rd_data[CNT_W-1:SPACE_BITS];
    fcnt       = rd_data[SPACE_BITS-1:0] + SPACE_BITS'(1);
    chunk_full = (acnt == {SPACE_BITS{1'b1}});
    row_empty  = (chunk_free[r_br] & ~(CHUNKS_PER_BRANCH'(1) << r_ch)) == '0;
    chunk_back = (fcnt == acnt);
    produce    = (r_kind == K_FAIL) || (r_kind == K_BUMP) || (r_kind == K_TAKE);

    wr_en    = 1'b0;
    wr_data  = rd_data;
    res_addr = '0;
    res_fail = 1'b1;
    case (r_kind)
      K_BUMP: begin
        wr_en    = 1'b1;
        wr_data  = {acnt + SPACE_BITS'(1), rd_data[SPACE_BITS-1:0]};
        res_addr = space_addr(r_next);
        res_fail = 1'b0;
      end
      K_TAKE: begin
        wr_en    = 1'b1;
        wr_data  = {SPACE_BITS'(1), rd_data[SPACE_BITS-1:0]};
        res_addr = space_addr(NEXT_W'(32'(r_idx) << SPACE_BITS));
        res_fail = 1'b0;
      end
      K_FREE: begin
        wr_en   = 1'b1;
        wr_data = chunk_back ? '0 : {acnt, fcnt};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign status.clear_last     = (32'(clr_addr) == 32'(TOTAL - 1));
  assign status.result_pending = produce;
  assign status.out_busy       = rsp.valid && !rsp.ready;

  // Counter memory: clearing pass after reset, then at most one write per word.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      counts[clr_addr] <= '0;
    end else if (cmd.update && wr_en) begin
      counts[r_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_addr <= clr_addr + CHUNK_W'(1);
    end
  end

  // Bitmaps and bank valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      branch_free <= '1;
      for (int b = 0; b < BRANCHES; b++) chunk_free[b] <= '1;
      bank_valid <= '0;
    end else if (cmd.update) begin
      case (r_kind)
        K_BUMP: begin
          if (chunk_full) begin
            chunk_free[r_br][r_ch] <= 1'b0;
            bank_valid[r_u]        <= 1'b0;
            if (row_empty) branch_free[r_br] <= 1'b0;
          end
        end
        K_TAKE: begin
          bank_valid[r_u] <= 1'b1;
        end
        K_FREE: begin
          if (chunk_back) begin
            chunk_free[r_br][r_ch] <= 1'b1;
            branch_free[r_br]      <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Bank chunk number and bump pointer; meaningful only while the bank is valid.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      case (r_kind)
        K_BUMP: bank_next[r_u] <= r_next + NEXT_W'(1);
        K_TAKE: begin
          bank_idx[r_u]  <= r_idx;
          bank_next[r_u] <= NEXT_W'((32'(r_idx) << SPACE_BITS) + 32'd1);
        end
        default: begin
        end
      endcase
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.update && produce) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && produce) begin
      rsp.address <= res_addr;
      rsp.failed  <= res_fail;
    end
  end

endmodule

@@ hw/rtl/two_level_bitmap_chunk_allocator.sv @@
// Top level of the two-level bitmap space allocator.
// Depends on tlba_pkg, tlba_if, tlba_ctrl and tlba_datapath.
//
//   Channel  Role    Word fields                  Handshake
//   req      sink    op, bank, free_address       valid && ready
//   rsp      source  address, failed              valid && ready
//
// On accepting a request word the block searches the bitmaps and reads the
// chunk counter memory; the write-back state then writes counters, bitmaps and
// bank state back, and no new word is accepted until write-back is done.
// After reset a clearing pass zeroes the counter memory, one entry a cycle,
// all BRANCHES * CHUNKS_PER_BRANCH entries (512 by default); req.ready stays low.
// Allocations and invalid commands give one response word, frees give none.
// A response waits in its register while rsp.ready is low; the next request is
// still accepted, and only its write-back waits, if it too gives a response.
module two_level_bitmap_chunk_allocator import tlba_pkg::*; #(
  parameter int CHUNKS_PER_BRANCH = CHUNKS_PER_BRANCH_DEF,
  parameter int BRANCHES          = BRANCHES_DEF,
  parameter int BRANCHES_PER_BANK = BRANCHES_PER_BANK_DEF,
  parameter int BANKS             = BANKS_DEF,
  parameter int SPACE_BITS        = SPACE_BITS_DEF,
  parameter int BYTE_BITS         = BYTE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  tlba_req_if.sink  req,
  tlba_rsp_if.source rsp
);

  tlba_cmd_t    cmd;
  tlba_status_t status;
  logic         in_ready;

  assign req.ready = in_ready;

  // The controller only sequences; all state of the allocator lives in the datapath.
  tlba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlba_datapath #(
    .CHUNKS_PER_BRANCH (CHUNKS_PER_BRANCH),
    .BRANCHES          (BRANCHES),
    .BRANCHES_PER_BANK (BRANCHES_PER_BANK),
    .BANKS             (BANKS),
    .SPACE_BITS        (SPACE_BITS),
    .BYTE_BITS         (BYTE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (req.op),
    .bank         (req.bank),
    .free_address (req.free_address),
    .rsp          (rsp)
  );

endmodule

@@ tb/two_level_bitmap_chunk_allocator_test.sv @@
// Self-checking test of the two-level bitmap space allocator, driving its request
// and response channels. Depends on tlba_pkg, tlba_if and the allocator RTL.
module two_level_bitmap_chunk_allocator_test import tlba_pkg::*; ();

  // Geometry of the instance under test; it is built with the package defaults.
  localparam int CPB      = CHUNKS_PER_BRANCH_DEF;
  localparam int NBR      = BRANCHES_DEF;
  localparam int BPB      = BRANCHES_PER_BANK_DEF;
  localparam int NBK      = BANKS_DEF;
  localparam int SB       = SPACE_BITS_DEF;
  localparam int BB       = BYTE_BITS_DEF;
  localparam int NCH      = NBR * CPB;
  localparam int CH_SHIFT = SB + BB;
  localparam int CH_W     = $clog2(NCH);

  // The package names only the two legal commands; these are the two codes the
  // block must reject.
  localparam logic [OP_W-1:0] OP_BAD2 = 2'd2;
  localparam logic [OP_W-1:0] OP_BAD3 = 2'd3;

  // Cycles without any handshake before the run is called hung. The limit covers
  // the clearing pass after reset as well as stalls and gaps.
  localparam int HANG_LIMIT = 4 * NCH + 1000;
  localparam int RANDOM_WORDS = 800;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              failed;
  } rsp_t;

  // One directed step. Where known is set, the response is typed in and is
  // checked as given rather than as predicted.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BANK_W-1:0] bank;
    logic [ADDR_W-1:0] free_address;
    logic              known;
    logic [ADDR_W-1:0] want_address;
    logic              want_failed;
  } step_t;

  localparam int PLAN_LEN = 23;
  localparam step_t PLAN [PLAN_LEN] = '{
    // Fresh region: each bank takes the first chunk of its own branch group.
    '{OP_ALLOC, 2'd0, 26'd0,          1'b1, 26'h0000000, 1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b1, 26'h3000000, 1'b0},
    '{OP_ALLOC, 2'd1, 26'd0,          1'b1, 26'h1000000, 1'b0},
    '{OP_ALLOC, 2'd2, 26'd0,          1'b1, 26'h2000000, 1'b0},
    // Invalid commands are refused whatever the other fields hold.
    '{OP_BAD2,  2'd0, 26'd0,          1'b1, 26'h0000000, 1'b1},
    '{OP_BAD3,  2'd3, 26'h3FFFFFF,    1'b1, 26'h0000000, 1'b1},
    // Bank 0 bumps to its second space.
    '{OP_ALLOC, 2'd0, 26'd0,          1'b1, 26'h0004000, 1'b0},
    // Two frees in chunk 0 return it while bank 0 is still filling it.
    '{OP_FREE,  2'd0, 26'h0000000,    1'b0, 26'd0,       1'b0},
    '{OP_FREE,  2'd2, 26'h0007FFF,    1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd0, 26'd0,          1'b0, 26'd0,       1'b0},
    // Frees of chunks nobody took leave a stray free count behind.
    '{OP_FREE,  2'd3, 26'h3FFFFFF,    1'b0, 26'd0,       1'b0},
    '{OP_FREE,  2'd1, 26'h1FFFFFF,    1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd1, 26'd0,          1'b0, 26'd0,       1'b0},
    // Bank 3 fills its chunk; the eighth space clears the chunk bit and the
    // next allocation moves on to the neighbouring chunk.
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd3, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_ALLOC, 2'd2, 26'd0,          1'b0, 26'd0,       1'b0},
    '{OP_BAD2,  2'd2, 26'h2AAAAAA,    1'b1, 26'h0000000, 1'b1}
  };

  logic clk;
  logic rst;

  tlba_req_if req ();
  tlba_rsp_if rsp ();

  two_level_bitmap_chunk_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator state as the testbench predicts it. It is updated at the edge at
  // which a request word is accepted, so the stimulus below always sees the
  // state that the block will see for the next word.
  // ---------------------------------------------------------------------------
  logic [NBR-1:0]    branch_room;
  logic [CPB-1:0]    chunk_room [NBR];
  logic [SB-1:0]     taken_count [NCH];
  logic [SB-1:0]     given_count [NCH];
  logic              bank_open [NBK];
  logic [CH_W-1:0]   bank_chunk [NBK];
  logic [NEXT_W-1:0] bank_ptr [NBK];

  // Responses the block still owes, oldest first.
  rsp_t pending_rsp [$];
  // Byte addresses handed out and not yet given back by the stimulus.
  logic [ADDR_W-1:0] live_spaces [$];

  int errors;
  int n_alloc, n_free, n_bad, n_checked, n_refused;
  int idle_cycles;
  // calm switches idling off for a stretch; quiet switches it off for good.
  logic calm;
  logic quiet;

  task automatic report(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic clear_model();
    branch_room = '1;
    for (int i = 0; i < NBR; i++) chunk_room[i] = '1;
    for (int i = 0; i < NCH; i++) begin
      taken_count[i] = '0;
      given_count[i] = '0;
    end
    for (int i = 0; i < NBK; i++) begin
      bank_open[i]  = 1'b0;
      bank_chunk[i] = '0;
      bank_ptr[i]   = '0;
    end
  endtask

  // Lowest branch of bank b's group that still has a free chunk, or -1.
  function automatic int lowest_open_branch(input int b);
    int br;
    for (int i = 0; i < BPB; i++) begin
      br = b * BPB + i;
      if (br < NBR && branch_room[br]) return br;
    end
    return -1;
  endfunction

  // Byte address of a space; the pointer is wider than the address allows, so
  // the top bit falls off.
  function automatic logic [ADDR_W-1:0] space_to_byte(input logic [NEXT_W-1:0] space);
    logic [NEXT_W+BB-1:0] wide;
    wide = {space, {BB{1'b0}}};
    return wide[ADDR_W-1:0];
  endfunction

  task automatic predict_alloc(input logic [BANK_W-1:0] bank, output rsp_t r);
    int pick;
    int br;
    int ch;
    int idx;
    r = '{address: '0, failed: 1'b1};
    if (branch_room == '0) return;
    // The preferred bank wins if its group has room, else the highest bank
    // that has any.
    pick = -1;
    if (int'(bank) < NBK && lowest_open_branch(int'(bank)) >= 0) begin
      pick = int'(bank);
    end else begin
      for (int b = 0; b < NBK; b++)
        if (lowest_open_branch(b) >= 0) pick = b;
    end
    if (pick < 0) return;
    r.failed = 1'b0;
    if (bank_open[pick]) begin
      // Bump allocation inside the bank's current chunk.
      idx = int'(bank_chunk[pick]) % NCH;
      r.address = space_to_byte(bank_ptr[pick]);
      bank_ptr[pick] = bank_ptr[pick] + NEXT_W'(1);
      if (taken_count[idx] == '1) begin
        // The counter wraps: the chunk is full and leaves the free bitmap.
        br = idx / CPB;
        ch = idx % CPB;
        chunk_room[br][ch] = 1'b0;
        bank_open[pick] = 1'b0;
        if (chunk_room[br] == '0) branch_room[br] = 1'b0;
      end
      taken_count[idx] = taken_count[idx] + SB'(1);
    end else begin
      // Take the lowest free chunk of the lowest free branch in the group.
      br = lowest_open_branch(pick);
      ch = 0;
      while (ch < CPB && !chunk_room[br][ch]) ch++;
      if (ch >= CPB) ch = 0;
      idx = br * CPB + ch;
      taken_count[idx] = SB'(1);
      bank_open[pick]  = 1'b1;
      bank_chunk[pick] = CH_W'(idx);
      bank_ptr[pick]   = NEXT_W'((idx << SB) + 1);
      r.address = space_to_byte(NEXT_W'(idx << SB));
    end
  endtask

  task automatic predict_free(input logic [ADDR_W-1:0] free_address);
    int idx;
    logic [SB-1:0] next_given;
    idx = int'(free_address >> CH_SHIFT);
    if (idx >= NCH) return;
    next_given = given_count[idx] + SB'(1);
    if (next_given == taken_count[idx]) begin
      // Every space handed out has come back: the chunk is free again.
      chunk_room[idx / CPB][idx % CPB] = 1'b1;
      branch_room[idx / CPB] = 1'b1;
      taken_count[idx] = '0;
      given_count[idx] = '0;
    end else begin
      given_count[idx] = next_given;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side. A word is held until the edge that accepts it; the next word
  // follows in the same step, so valid only drops between words for a gap or a drain.
  // ---------------------------------------------------------------------------
  task automatic send_word(input step_t s);
    rsp_t r;
    req.valid        <= 1'b1;
    req.op           <= s.op;
    req.bank         <= s.bank;
    req.free_address <= s.free_address;
    do @(posedge clk); while (!req.ready);
    if (s.op == OP_ALLOC) begin
      predict_alloc(s.bank, r);
      n_alloc++;
      if (r.failed) n_refused++;
      else live_spaces.push_back(r.address);
    end else if (s.op == OP_FREE) begin
      predict_free(s.free_address);
      n_free++;
    end else begin
      r = '{address: '0, failed: 1'b1};
      n_bad++;
    end
    if (s.op != OP_FREE) begin
      if (s.known) pending_rsp.push_back('{address: s.want_address, failed: s.want_failed});
      else pending_rsp.push_back(r);
    end
  endtask

  // A random burst of idle cycles on the request side.
  task automatic sender_gap();
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Hold off until the block owes nothing, so a word lands on an idle block.
  task automatic drain_responses();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic step_t alloc_step(input logic [BANK_W-1:0] bank);
    return '{op: OP_ALLOC, bank: bank, free_address: ADDR_W'($urandom),
             known: 1'b0, want_address: '0, want_failed: 1'b0};
  endfunction

  // Free of a space still handed out, with random bits below the space.
  function automatic step_t return_step();
    int k;
    logic [ADDR_W-1:0] a;
    k = $urandom_range(0, live_spaces.size() - 1);
    a = live_spaces[k];
    live_spaces.delete(k);
    a = a | ADDR_W'($urandom_range(0, (1 << BB) - 1));
    return '{op: OP_FREE, bank: BANK_W'($urandom), free_address: a,
             known: 1'b0, want_address: '0, want_failed: 1'b0};
  endfunction

  // Mostly well-formed traffic: allocations and frees of handed-out spaces.
  // The rest is frees of arbitrary addresses and invalid commands.
  function automatic step_t random_step();
    int pick;
    step_t s;
    pick = $urandom_range(0, 99);
    s = alloc_step(BANK_W'($urandom));
    if (pick < 52) begin
      s.op = OP_ALLOC;
    end else if (pick < 88 && live_spaces.size() != 0) begin
      s = return_step();
    end else if (pick < 94) begin
      s.op = OP_FREE;
    end else if (pick < 97) begin
      s.op = OP_BAD2;
    end else begin
      s.op = OP_BAD3;
    end
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    n_alloc = 0;
    n_free = 0;
    n_bad = 0;
    n_checked = 0;
    n_refused = 0;
    calm = 1'b0;
    quiet = 1'b0;
    clear_model();
    req.valid        <= 1'b0;
    req.op           <= OP_ALLOC;
    req.bank         <= '0;
    req.free_address <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed steps right after reset; the clearing pass holds ready low first.
    for (int i = 0; i < PLAN_LEN; i++) begin
      send_word(PLAN[i]);
      sender_gap();
    end
    drain_responses();

    // Random traffic, in stretches with and without idling.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send_word(random_step());
      if (i % 250 == 125) drain_responses();
      else sender_gap();
    end

    // Last part, no idling: one allocation per bank, then spaces given back
    // and mixed traffic, all back to back.
    quiet = 1'b1;
    calm = 1'b0;
    for (int i = 0; i < 4; i++) send_word(alloc_step(BANK_W'(i)));
    for (int i = 0; i < 60 && live_spaces.size() != 0; i++) send_word(return_step());
    for (int i = 0; i < 60; i++) send_word(random_step());

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d allocations (%0d refused), %0d frees, %0d invalid commands;",
             n_alloc, n_refused, n_free, n_bad);
    $display("%0d responses checked, with idle gaps, stalls and back-to-back words.",
             n_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: random stall bursts, none once the run turns quiet.
  // ---------------------------------------------------------------------------
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Every response word is compared with the oldest one the block owes.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        report("response with none owed, address", rsp.address, 0);
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        if (rsp.address !== want.address) report("address", rsp.address, want.address);
        if (rsp.failed !== want.failed) report("failed", rsp.failed, want.failed);
      end
    end
  end

  // Hang detection: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", HANG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
hw/rtl/tlba_pkg.sv
hw/rtl/tlba_if.sv
hw/rtl/tlba_ctrl.sv
hw/rtl/tlba_datapath.sv
hw/rtl/two_level_bitmap_chunk_allocator.sv
tb/two_level_bitmap_chunk_allocator_test.sv
